@@ rtl/core/wnp_pkg.sv @@
// Shared types and constants for the Worley nearest-point noise block.
package wnp_pkg;

	localparam int NUM_POINTS      = 20;
	localparam int COORD_FRAC_BITS = 8;
	localparam int VALUE_FRAC_BITS = 12;

	localparam int COORD_W = 20;
	localparam int IDX_W   = 5;
	localparam int PIX_W   = 12;
	localparam int WIDTH_W = 13;
	localparam int VALUE_W = 22;
	localparam int DIST_W  = 21;

	localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(64);
	localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(4096);
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(512);

	// internal coordinate width: wide enough for a stored point and a shifted pixel
	localparam int CRD_W = (COORD_W > PIX_W + COORD_FRAC_BITS) ?
		COORD_W : PIX_W + COORD_FRAC_BITS;
	localparam int PT_IDX_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
	localparam int PT_CNT_W = $clog2(NUM_POINTS + 1);

	// squared distance and its floor root
	localparam int SQ_W       = 2 * CRD_W + 1;
	localparam int ROOT_W     = (SQ_W + 1) / 2;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int REM_W      = ROOT_W + 3;
	localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

	// q = floor((dist << SCALE_SH + w) / (2w)) is round(4*dist*2^12 / (w*2^frac))
	localparam int SCALE_SH  = VALUE_FRAC_BITS + 3 - COORD_FRAC_BITS;
	localparam int NUM_W     = ROOT_W + SCALE_SH + 1;
	localparam int DEN_W     = WIDTH_W + 1;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);

	localparam logic [VALUE_W-1:0] VALUE_ONE = VALUE_W'(1 << VALUE_FRAC_BITS);

	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	typedef enum logic [0:0] {
		KIND_LOAD  = 1'b0,
		KIND_PIXEL = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   point_index;
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic [PIX_W-1:0]   pixel_x;
		logic [PIX_W-1:0]   pixel_y;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] noise_value;
		logic [DIST_W-1:0]         nearest_distance;
	} result_t;

	typedef enum logic [0:0] {
		OP_LOAD  = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	// queue entry: a load carries the point, a pixel carries its scaled position
	typedef struct packed {
		op_t                 op;
		logic [PT_IDX_W-1:0] slot;
		logic [CRD_W-1:0]    cx;
		logic [CRD_W-1:0]    cy;
	} qent_t;

endpackage

@@ rtl/core/wnp_front.sv @@
// Front end: takes input transfers, classifies them and fills the work queue.
module wnp_front (
	input  logic             item_valid,
	output logic             item_stall,
	input  wnp_pkg::item_t   item,
	input  logic             q_full,
	output logic             q_push,
	output wnp_pkg::qent_t   q_entry
);

	logic is_pixel;
	logic slot_ok;

	assign is_pixel   = (item.kind == wnp_pkg::KIND_PIXEL);
	assign slot_ok    = ({1'b0, item.point_index} < (wnp_pkg::IDX_W + 1)'(wnp_pkg::NUM_POINTS));
	assign item_stall = q_full;

	// loads to a slot beyond the table are taken and dropped
	assign q_push = item_valid && !q_full && (is_pixel || slot_ok);

	always_comb begin
		q_entry      = '0;
		q_entry.slot = item.point_index[wnp_pkg::PT_IDX_W-1:0];
		if (is_pixel) begin
			q_entry.op = wnp_pkg::OP_PIXEL;
			q_entry.cx = wnp_pkg::CRD_W'({item.pixel_x, {wnp_pkg::COORD_FRAC_BITS{1'b0}}});
			q_entry.cy = wnp_pkg::CRD_W'({item.pixel_y, {wnp_pkg::COORD_FRAC_BITS{1'b0}}});
		end else begin
			q_entry.op = wnp_pkg::OP_LOAD;
			q_entry.cx = wnp_pkg::CRD_W'(item.point_x);
			q_entry.cy = wnp_pkg::CRD_W'(item.point_y);
		end
	end

endmodule

@@ rtl/core/wnp_fifo.sv @@
// Short work queue between front end and back end.
module wnp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wnp_pkg::qent_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output wnp_pkg::qent_t data
);

	wnp_pkg::qent_t                 mem_q [wnp_pkg::FIFO_DEPTH];
	logic [wnp_pkg::FIFO_AW-1:0]    wr_ptr_q;
	logic [wnp_pkg::FIFO_AW-1:0]    rd_ptr_q;
	logic [wnp_pkg::FIFO_AW:0]      count_q;

	assign full  = (count_q == (wnp_pkg::FIFO_AW + 1)'(wnp_pkg::FIFO_DEPTH));
	assign valid = (count_q != '0);
	assign data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ rtl/core/wnp_sqrt.sv @@
// Floor square root, one result bit per cycle.
module wnp_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wnp_pkg::SQ_W-1:0]    radicand,
	output logic                        done,
	output logic [wnp_pkg::ROOT_W-1:0]  root
);

	logic [wnp_pkg::RAD_W-1:0]      rad_q;
	logic [wnp_pkg::REM_W-1:0]      rem_q;
	logic [wnp_pkg::ROOT_W-1:0]     root_q;
	logic [wnp_pkg::ROOT_CNT_W-1:0] cnt_q;
	logic                           done_q;

	logic [wnp_pkg::REM_W-1:0]      rem_sh;
	logic [wnp_pkg::REM_W-1:0]      trial;
	logic                           ge;

	always_comb begin
		rem_sh = {rem_q[wnp_pkg::REM_W-3:0], rad_q[wnp_pkg::RAD_W-1 -: 2]};
		trial  = wnp_pkg::REM_W'({root_q, 2'b01});
		ge     = (rem_sh >= trial);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= wnp_pkg::RAD_W'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[wnp_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[wnp_pkg::ROOT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == wnp_pkg::ROOT_CNT_W'(1));
			if (start)
				cnt_q <= wnp_pkg::ROOT_CNT_W'(wnp_pkg::ROOT_W);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ rtl/core/wnp_div.sv @@
// Restoring divider for the distance scaling, one quotient bit per cycle.
module wnp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wnp_pkg::NUM_W-1:0]   num,
	input  logic [wnp_pkg::DEN_W-1:0]   den,
	output logic                        done,
	output logic [wnp_pkg::NUM_W-1:0]   quo
);

	logic [wnp_pkg::NUM_W-1:0]      num_q;
	logic [wnp_pkg::DEN_W-1:0]      den_q;
	logic [wnp_pkg::DEN_W-1:0]      rem_q;
	logic [wnp_pkg::NUM_W-1:0]      quo_q;
	logic [wnp_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                           done_q;

	logic [wnp_pkg::DEN_W:0]        rem_sh;
	logic [wnp_pkg::DEN_W:0]        rem_sub;
	logic                           ge;

	always_comb begin
		rem_sh  = {rem_q, num_q[wnp_pkg::NUM_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		ge      = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[wnp_pkg::NUM_W-2:0], 1'b0};
			rem_q <= ge ? rem_sub[wnp_pkg::DEN_W-1:0] : rem_sh[wnp_pkg::DEN_W-1:0];
			quo_q <= {quo_q[wnp_pkg::NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == wnp_pkg::DIV_CNT_W'(1));
			if (start)
				cnt_q <= wnp_pkg::DIV_CNT_W'(wnp_pkg::NUM_W);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ rtl/core/wnp_back.sv @@
// Back end: point table, nearest-point scan, root and scaling, result register.
module wnp_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [wnp_pkg::WIDTH_W-1:0]  image_width,
	input  logic                         q_valid,
	input  wnp_pkg::qent_t               q_data,
	output logic                         q_pop,
	output logic                         result_valid,
	input  logic                         result_stall,
	output wnp_pkg::result_t             result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SQRT,
		ST_DIV,
		ST_OUT
	} state_t;

	localparam logic [wnp_pkg::PT_IDX_W-1:0] LAST_IDX = wnp_pkg::PT_IDX_W'(wnp_pkg::NUM_POINTS - 1);

	state_t                          state_q;
	logic [wnp_pkg::PT_IDX_W-1:0]    rd_idx_q;
	logic                            issue_q;
	logic                            sqrt_start_q;
	logic                            div_start_q;
	logic                            result_valid_q;

	logic [wnp_pkg::CRD_W-1:0]       tab_x_q [wnp_pkg::NUM_POINTS];
	logic [wnp_pkg::CRD_W-1:0]       tab_y_q [wnp_pkg::NUM_POINTS];

	logic [wnp_pkg::CRD_W-1:0]       px_q;
	logic [wnp_pkg::CRD_W-1:0]       py_q;
	logic [wnp_pkg::SQ_W-1:0]        best_q;
	logic [wnp_pkg::ROOT_W-1:0]      dist_q;
	logic [wnp_pkg::NUM_W-1:0]       num_q;
	logic [wnp_pkg::DEN_W-1:0]       den_q;
	logic [wnp_pkg::NUM_W-1:0]       quo_q;
	wnp_pkg::result_t                result_q;

	logic [wnp_pkg::CRD_W-1:0]       x_s1;
	logic [wnp_pkg::CRD_W-1:0]       y_s1;
	logic                            v_s1;
	logic                            last_s1;
	logic [2*wnp_pkg::CRD_W-1:0]     sqx_s2;
	logic [2*wnp_pkg::CRD_W-1:0]     sqy_s2;
	logic                            v_s2;
	logic                            last_s2;
	logic                            done_s3;

	logic [wnp_pkg::CRD_W-1:0]       dx;
	logic [wnp_pkg::CRD_W-1:0]       dy;
	logic [wnp_pkg::SQ_W-1:0]        sum;
	logic [wnp_pkg::WIDTH_W-1:0]     width_sat;
	logic                            out_load;

	logic                            sqrt_done;
	logic [wnp_pkg::ROOT_W-1:0]      sqrt_root;
	logic                            div_done;
	logic [wnp_pkg::NUM_W-1:0]       div_quo;

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign out_load = (state_q == ST_OUT) && (!result_valid_q || !result_stall);

	always_comb begin
		dx  = (px_q >= x_s1) ? px_q - x_s1 : x_s1 - px_q;
		dy  = (py_q >= y_s1) ? py_q - y_s1 : y_s1 - py_q;
		sum = {1'b0, sqx_s2} + {1'b0, sqy_s2};
		if (image_width < wnp_pkg::WIDTH_MIN)
			width_sat = wnp_pkg::WIDTH_MIN;
		else if (image_width > wnp_pkg::WIDTH_MAX)
			width_sat = wnp_pkg::WIDTH_MAX;
		else
			width_sat = image_width;
	end

	// point table, one read port driven by the scan counter
	always_ff @(posedge clk) begin
		if (q_pop && q_data.op == wnp_pkg::OP_LOAD) begin
			tab_x_q[q_data.slot] <= q_data.cx;
			tab_y_q[q_data.slot] <= q_data.cy;
		end
		x_s1 <= tab_x_q[rd_idx_q];
		y_s1 <= tab_y_q[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			px_q   <= q_data.cx;
			py_q   <= q_data.cy;
			best_q <= '1;
		end else if (v_s2 && sum < best_q) begin
			best_q <= sum;
		end
		sqx_s2 <= {{wnp_pkg::CRD_W{1'b0}}, dx} * {{wnp_pkg::CRD_W{1'b0}}, dx};
		sqy_s2 <= {{wnp_pkg::CRD_W{1'b0}}, dy} * {{wnp_pkg::CRD_W{1'b0}}, dy};
		if (sqrt_done) begin
			dist_q <= sqrt_root;
			num_q  <= wnp_pkg::NUM_W'({sqrt_root, {wnp_pkg::SCALE_SH{1'b0}}})
				+ wnp_pkg::NUM_W'(width_sat);
			den_q  <= {width_sat, 1'b0};
		end
		if (div_done)
			quo_q <= div_quo;
		if (out_load) begin
			result_q.noise_value      <= wnp_pkg::VALUE_ONE - quo_q[wnp_pkg::VALUE_W-1:0];
			result_q.nearest_distance <= wnp_pkg::DIST_W'(dist_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			v_s1    <= issue_q;
			last_s1 <= issue_q && (rd_idx_q == LAST_IDX);
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			done_s3 <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rd_idx_q       <= '0;
			issue_q        <= 1'b0;
			sqrt_start_q   <= 1'b0;
			div_start_q    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			sqrt_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			if (result_valid_q && !result_stall)
				result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid && q_data.op == wnp_pkg::OP_PIXEL) begin
						state_q  <= ST_SCAN;
						rd_idx_q <= '0;
						issue_q  <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						if (rd_idx_q == LAST_IDX)
							issue_q <= 1'b0;
						else
							rd_idx_q <= rd_idx_q + 1'b1;
					end
					// the minimum is final once the last point leaves the compare stage
					if (done_s3) begin
						state_q      <= ST_SQRT;
						sqrt_start_q <= 1'b1;
					end
				end
				ST_SQRT: begin
					if (sqrt_done) begin
						state_q     <= ST_DIV;
						div_start_q <= 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	wnp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start_q),
		.radicand (best_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	wnp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_sqrt_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == ST_SQRT)
		else $error("root finished outside its state");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("quotient finished outside its state");

	a_sqrt_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT && sqrt_done) |=> (state_q == ST_DIV && div_start_q))
		else $error("divider not started after root");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (result_valid_q && state_q == ST_IDLE))
		else $error("result register not loaded");
`endif

endmodule

@@ rtl/core/worley_nearest_point_noise.sv @@
// Top level of the Worley nearest-point noise block.
// Load transfers write one feature point into the table; pixel transfers return the
// floor Euclidean distance to the nearest stored point (8 fraction bits) and
// 1 - 4*distance/width in signed Q.12, unclamped. Transfers pass a four-entry queue,
// so the input keeps flowing while a pixel is worked on, until the queue is full. A load
// is written into the table as it leaves the queue. A pixel holds the back end from
// leaving the queue to its result being presented: a scan of the table one point per
// cycle through a three-stage distance pipeline, then a serial square root of 21 steps
// and a serial divider of 29 steps, each one bit per cycle. Load every point before the
// first pixel; the width register is saturated to 64..4096 when used.
module worley_nearest_point_noise (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  wnp_pkg::item_t               item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output wnp_pkg::result_t             result,
	input  logic                         cfg_we,
	input  logic [wnp_pkg::WIDTH_W-1:0]  cfg_wdata
);

	logic [wnp_pkg::WIDTH_W-1:0] width_q;

	logic           q_full;
	logic           q_push;
	wnp_pkg::qent_t q_entry;
	logic           q_valid;
	logic           q_pop;
	wnp_pkg::qent_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			width_q <= wnp_pkg::WIDTH_RESET;
		else if (cfg_we)
			width_q <= cfg_wdata;
	end

	wnp_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_entry)
	);

	wnp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_entry),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.data      (q_data)
	);

	wnp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (width_q),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
